### rtl/ncfs_pkg.sv
package ncfs_pkg;

    localparam int WB = 32;
    localparam int FB = 24;
    localparam int IW = 16;

    localparam int MW    = 2 * WB;
    localparam int M2W   = 4 * WB;
    localparam int LIMBS = M2W / WB;
    localparam int PW    = 5 * WB;
    localparam int NT    = (PW + 1 > 2 * WB + 3 * FB + 1) ? PW + 1 : 2 * WB + 3 * FB + 1;
    localparam int NW    = NT + 2;
    localparam int DW    = M2W + 2;
    localparam int AW    = ((NW > DW) ? NW : DW) + 1;
    localparam int BW    = DW + 1;
    localparam int MAW   = 2 * WB + FB + 2;
    localparam int MBW   = 2 * WB + 1;

    localparam logic [1:0] REG_NONE = 2'd0;
    localparam logic [1:0] REG_REAL = 2'd1;
    localparam logic [1:0] REG_IMAG = 2'd2;

    typedef struct packed {
        logic signed [WB-1:0] z_real;
        logic signed [WB-1:0] z_imag;
        logic [IW-1:0]        iter_index;
    } t_in;

    typedef struct packed {
        logic signed [WB-1:0] next_real;
        logic signed [WB-1:0] next_imag;
        logic [1:0]           region;
        logic [WB-1:0]        saved_magnitude;
        logic [IW-1:0]        saved_iteration;
        logic                 overflow;
    } t_out;

    typedef struct packed {
        logic          nre;
        logic          nim;
        logic [1:0]    region;
        logic [IW-1:0] iter;
    } t_side;

endpackage

### rtl/ncfs_div.sv
module ncfs_div #(
    parameter int AW = 8,
    parameter int BW = 8,
    parameter int QB = 8
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [AW-1:0] i_a,
    input  logic [BW-1:0] i_b,
    output logic [QB-1:0] o_q,
    output logic          o_big
);

    localparam int CW = ((AW > BW + QB) ? AW : BW + QB) + 1;

    logic [CW-1:0] r_rem [QB+1];
    logic [BW-1:0] r_b   [QB+1];
    logic [QB-1:0] r_q   [QB+1];
    logic          r_big [QB+1];

    logic [CW-1:0] n_rem [QB+1];
    logic [QB-1:0] n_q   [QB+1];

    always_comb begin
        logic [CW-1:0] t;
        logic          ge;
        n_rem[0] = CW'(i_a);
        n_q[0]   = '0;
        for (int k = 1; k <= QB; k++) begin
            t  = CW'(r_b[k-1]) << (QB - k);
            ge = r_rem[k-1] >= t;
            n_rem[k] = ge ? r_rem[k-1] - t : r_rem[k-1];
            n_q[k]   = r_q[k-1] | (QB'(ge) << (QB - k));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= n_rem[0];
            r_q[0]   <= n_q[0];
            r_b[0]   <= i_b;
            r_big[0] <= CW'(i_a) >= (CW'(i_b) << QB);
            for (int k = 1; k <= QB; k++) begin
                r_rem[k] <= n_rem[k];
                r_q[k]   <= n_q[k];
                r_b[k]   <= r_b[k-1];
                r_big[k] <= r_big[k-1];
            end
        end
    end

    assign o_q   = r_q[QB];
    assign o_big = r_big[QB];

endmodule

### rtl/newton_cubic_fractal_step_core.sv
// One Newton step of z^3 + 1 on a signed Q8.24 point, with region classification.
// Input channel: i_valid / o_stall carry one point (i_data) per beat.
// Output channel: o_valid / i_stall carry one result (o_data) per beat.
// Config: i_cfg_we writes i_cfg_wdata into ratio_mode; write only while idle.
// Throughput: one beat per cycle in both directions while no stall holds the pipeline.
// Pipeline: 9 arithmetic stages (abs, squares, |z|^2, |z|^4 partial products
// and sum, numerator products and sum, signed numerators, rounding operands),
// then a 33-stage restoring divider (one quotient bit per stage plus a range
// check), then the output register.
// Stall: a skid register behind the output register takes one more beat while
// i_stall is high; o_stall rises only when that skid register is full, and
// then the whole pipeline holds until the skid register drains.
// Reset: synchronous active low; clears all valid bits (including the skid
// register's valid bit) and ratio_mode. Results in flight are dropped.
module newton_cubic_fractal_step_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  ncfs_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_stall,
    output ncfs_pkg::t_out o_data,
    input  logic           i_cfg_we,
    input  logic           i_cfg_wdata
);

    localparam int WB  = ncfs_pkg::WB;
    localparam int FB  = ncfs_pkg::FB;
    localparam int IW  = ncfs_pkg::IW;
    localparam int MW  = ncfs_pkg::MW;
    localparam int M2W = ncfs_pkg::M2W;
    localparam int LB  = ncfs_pkg::LIMBS;
    localparam int PW  = ncfs_pkg::PW;
    localparam int NW  = ncfs_pkg::NW;
    localparam int DW  = ncfs_pkg::DW;
    localparam int AW  = ncfs_pkg::AW;
    localparam int BW  = ncfs_pkg::BW;
    localparam int MAW = ncfs_pkg::MAW;
    localparam int MBW = ncfs_pkg::MBW;
    localparam int NS  = 10 + WB;

    logic          r_ratio;
    logic [NS-1:0] r_v;
    logic          en;

    // stage 1
    logic [WB-1:0] r1_ax, r1_ay;
    logic          r1_xn, r1_yn;
    logic [IW-1:0] r1_iter;
    // stage 2
    logic [MW-1:0] r2_r, r2_i, r2_p;
    logic [WB-1:0] r2_ax, r2_ay;
    logic          r2_xn, r2_yn;
    logic [IW-1:0] r2_iter;
    // stage 3
    logic [MW-1:0]        r3_m, r3_dmax, r3_p;
    logic signed [MW:0]   r3_diff;
    logic [1:0]           r3_reg;
    logic [WB-1:0]        r3_ax, r3_ay;
    logic                 r3_xn, r3_yn;
    logic [IW-1:0]        r3_iter;
    // stage 4
    logic [MW-1:0]        r4_ll, r4_lh, r4_hh, r4_p;
    logic [MAW-1:0]       r4_ma;
    logic [MBW-1:0]       r4_mb;
    logic signed [MW:0]   r4_diff;
    logic [1:0]           r4_reg;
    logic [WB-1:0]        r4_ax, r4_ay;
    logic                 r4_xn, r4_yn;
    logic [IW-1:0]        r4_iter;
    // stage 5
    logic [M2W-1:0]       r5_m2;
    logic [MW-1:0]        r5_p;
    logic [MAW-1:0]       r5_ma;
    logic [MBW-1:0]       r5_mb;
    logic signed [MW:0]   r5_diff;
    logic [1:0]           r5_reg;
    logic [WB-1:0]        r5_ax, r5_ay;
    logic                 r5_xn, r5_yn;
    logic [IW-1:0]        r5_iter;
    // stage 6
    logic [MW-1:0]        r6_xp [LB];
    logic [MW-1:0]        r6_yp [LB];
    logic [M2W-1:0]       r6_m2;
    logic [MW-1:0]        r6_p;
    logic [MAW-1:0]       r6_ma;
    logic [MBW-1:0]       r6_mb;
    logic signed [MW:0]   r6_diff;
    logic [1:0]           r6_reg;
    logic                 r6_xn, r6_yn;
    logic [IW-1:0]        r6_iter;
    // stage 7
    logic [PW-1:0]        r7_xm, r7_ym;
    logic [M2W-1:0]       r7_m2;
    logic [MW-1:0]        r7_p;
    logic [MAW-1:0]       r7_ma;
    logic [MBW-1:0]       r7_mb;
    logic signed [MW:0]   r7_diff;
    logic [1:0]           r7_reg;
    logic                 r7_xn, r7_yn;
    logic [IW-1:0]        r7_iter;
    // stage 8
    logic signed [NW-1:0] r8_nre, r8_nim;
    logic [DW-1:0]        r8_d;
    logic [MAW-1:0]       r8_ma;
    logic [MBW-1:0]       r8_mb;
    logic [1:0]           r8_reg;
    logic [IW-1:0]        r8_iter;
    // stage 9
    logic [AW-1:0]        r9_are, r9_aim;
    logic [BW-1:0]        r9_b;
    logic [MAW-1:0]       r9_ma;
    logic [MBW-1:0]       r9_mb;
    ncfs_pkg::t_side      r9_sd;

    ncfs_pkg::t_side      r_sd [WB+1];

    logic [WB-1:0] q_re, q_im, q_m;
    logic          big_re, big_im, big_m;

    logic           r_out_v, r_sk_v;
    ncfs_pkg::t_out r_out, r_sk, n_fmt;

    assign en      = !r_sk_v;
    assign o_stall = r_sk_v;
    assign o_valid = r_out_v;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio <= 1'b0;
        end else if (i_cfg_we) begin
            r_ratio <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[NS-2:0], i_valid};
        end
    end

    logic [MW-1:0]        n3_m, n3_dmax;
    logic signed [MW:0]   n3_diff;
    logic [1:0]           n3_reg;
    logic [MBW-1:0]       n4_den;
    logic [MAW-1:0]       n4_num;
    logic [PW-1:0]        n7_xm, n7_ym;
    logic signed [NW-1:0] s_xm, s_ym, s_df, s_p;
    logic [NW-1:0]        a_re, a_im;

    always_comb begin
        n3_m    = r2_r + r2_i;
        n3_diff = $signed({1'b0, r2_r}) - $signed({1'b0, r2_i});
        if (r2_r > r2_i) begin
            n3_reg  = ncfs_pkg::REG_REAL;
        end else if (r2_i > r2_r) begin
            n3_reg  = ncfs_pkg::REG_IMAG;
        end else begin
            n3_reg  = ncfs_pkg::REG_NONE;
        end
        n3_dmax = (r2_r > r2_i) ? r2_r : r2_i;

        n4_num = r_ratio ? (MAW'(r3_m) << FB) : MAW'(r3_m);
        n4_den = r_ratio ? MBW'(r3_dmax) : (MBW'(1) << FB);

        n7_xm = '0;
        n7_ym = '0;
        for (int j = 0; j < LB; j++) begin
            n7_xm = n7_xm + (PW'(r6_xp[j]) << (j * WB));
            n7_ym = n7_ym + (PW'(r6_yp[j]) << (j * WB));
        end

        s_xm = NW'({r7_xm, 1'b0});
        s_ym = NW'({r7_ym, 1'b0});
        s_df = NW'(r7_diff) <<< (3 * FB);
        s_p  = NW'({r7_p, 1'b0}) <<< (3 * FB);

        a_re = r8_nre[NW-1] ? NW'(-r8_nre) : NW'(r8_nre);
        a_im = r8_nim[NW-1] ? NW'(-r8_nim) : NW'(r8_nim);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_xn   <= i_data.z_real[WB-1];
            r1_yn   <= i_data.z_imag[WB-1];
            r1_ax   <= i_data.z_real[WB-1] ? WB'(-i_data.z_real) : WB'(i_data.z_real);
            r1_ay   <= i_data.z_imag[WB-1] ? WB'(-i_data.z_imag) : WB'(i_data.z_imag);
            r1_iter <= i_data.iter_index;

            r2_r    <= MW'(r1_ax) * MW'(r1_ax);
            r2_i    <= MW'(r1_ay) * MW'(r1_ay);
            r2_p    <= MW'(r1_ax) * MW'(r1_ay);
            r2_ax   <= r1_ax;
            r2_ay   <= r1_ay;
            r2_xn   <= r1_xn;
            r2_yn   <= r1_yn;
            r2_iter <= r1_iter;

            r3_m    <= n3_m;
            r3_dmax <= n3_dmax;
            r3_diff <= n3_diff;
            r3_reg  <= n3_reg;
            r3_p    <= r2_p;
            r3_ax   <= r2_ax;
            r3_ay   <= r2_ay;
            r3_xn   <= r2_xn;
            r3_yn   <= r2_yn;
            r3_iter <= r2_iter;

            r4_ll   <= MW'(r3_m[WB-1:0]) * MW'(r3_m[WB-1:0]);
            r4_lh   <= MW'(r3_m[WB-1:0]) * MW'(r3_m[MW-1:WB]);
            r4_hh   <= MW'(r3_m[MW-1:WB]) * MW'(r3_m[MW-1:WB]);
            r4_ma   <= (n4_num << 1) + MAW'(n4_den);
            r4_mb   <= n4_den << 1;
            r4_p    <= r3_p;
            r4_diff <= r3_diff;
            r4_reg  <= r3_reg;
            r4_ax   <= r3_ax;
            r4_ay   <= r3_ay;
            r4_xn   <= r3_xn;
            r4_yn   <= r3_yn;
            r4_iter <= r3_iter;

            r5_m2   <= (M2W'(r4_hh) << MW) + (M2W'(r4_lh) << (WB + 1)) + M2W'(r4_ll);
            r5_p    <= r4_p;
            r5_ma   <= r4_ma;
            r5_mb   <= r4_mb;
            r5_diff <= r4_diff;
            r5_reg  <= r4_reg;
            r5_ax   <= r4_ax;
            r5_ay   <= r4_ay;
            r5_xn   <= r4_xn;
            r5_yn   <= r4_yn;
            r5_iter <= r4_iter;

            for (int j = 0; j < LB; j++) begin
                r6_xp[j] <= MW'(r5_ax) * MW'(r5_m2[j*WB +: WB]);
                r6_yp[j] <= MW'(r5_ay) * MW'(r5_m2[j*WB +: WB]);
            end
            r6_m2   <= r5_m2;
            r6_p    <= r5_p;
            r6_ma   <= r5_ma;
            r6_mb   <= r5_mb;
            r6_diff <= r5_diff;
            r6_reg  <= r5_reg;
            r6_xn   <= r5_xn;
            r6_yn   <= r5_yn;
            r6_iter <= r5_iter;

            r7_xm   <= n7_xm;
            r7_ym   <= n7_ym;
            r7_m2   <= r6_m2;
            r7_p    <= r6_p;
            r7_ma   <= r6_ma;
            r7_mb   <= r6_mb;
            r7_diff <= r6_diff;
            r7_reg  <= r6_reg;
            r7_xn   <= r6_xn;
            r7_yn   <= r6_yn;
            r7_iter <= r6_iter;

            r8_nre  <= (r7_xn ? -s_xm : s_xm) - s_df;
            r8_nim  <= (r7_yn ? -s_ym : s_ym) + ((r7_xn ^ r7_yn) ? -s_p : s_p);
            r8_d    <= DW'(r7_m2) + (DW'(r7_m2) << 1);
            r8_ma   <= r7_ma;
            r8_mb   <= r7_mb;
            r8_reg  <= r7_reg;
            r8_iter <= r7_iter;

            r9_are       <= AW'({a_re, 1'b0}) + AW'(r8_d);
            r9_aim       <= AW'({a_im, 1'b0}) + AW'(r8_d);
            r9_b         <= {r8_d, 1'b0};
            r9_ma        <= r8_ma;
            r9_mb        <= r8_mb;
            r9_sd.nre    <= r8_nre[NW-1];
            r9_sd.nim    <= r8_nim[NW-1];
            r9_sd.region <= r8_reg;
            r9_sd.iter   <= r8_iter;

            r_sd[0] <= r9_sd;
            for (int k = 1; k <= WB; k++) begin
                r_sd[k] <= r_sd[k-1];
            end
        end
    end

    ncfs_div #(.AW(AW), .BW(BW), .QB(WB)) u_div_re (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (r9_are),
        .i_b   (r9_b),
        .o_q   (q_re),
        .o_big (big_re)
    );

    ncfs_div #(.AW(AW), .BW(BW), .QB(WB)) u_div_im (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (r9_aim),
        .i_b   (r9_b),
        .o_q   (q_im),
        .o_big (big_im)
    );

    ncfs_div #(.AW(MAW), .BW(MBW), .QB(WB)) u_div_mag (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (r9_ma),
        .i_b   (r9_mb),
        .o_q   (q_m),
        .o_big (big_m)
    );

    always_comb begin
        logic [WB-1:0] lim_re, lim_im, sr, si;
        logic          sat_re, sat_im, has_reg;
        lim_re  = {r_sd[WB].nre, {(WB-1){~r_sd[WB].nre}}};
        lim_im  = {r_sd[WB].nim, {(WB-1){~r_sd[WB].nim}}};
        sat_re  = big_re || (q_re > lim_re);
        sat_im  = big_im || (q_im > lim_im);
        sr      = sat_re ? lim_re : q_re;
        si      = sat_im ? lim_im : q_im;
        has_reg = r_sd[WB].region != ncfs_pkg::REG_NONE;

        n_fmt.next_real       = r_sd[WB].nre ? -sr : sr;
        n_fmt.next_imag       = r_sd[WB].nim ? -si : si;
        n_fmt.region          = r_sd[WB].region;
        n_fmt.saved_magnitude = !has_reg ? '0 : (big_m ? '1 : q_m);
        n_fmt.saved_iteration = has_reg ? r_sd[WB].iter : '0;
        n_fmt.overflow        = sat_re || sat_im || (has_reg && big_m);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_sk_v  <= 1'b0;
        end else if (r_sk_v) begin
            if (!i_stall) begin
                r_sk_v <= 1'b0;
            end
        end else if (r_v[NS-1]) begin
            if (!r_out_v || !i_stall) begin
                r_out_v <= 1'b1;
            end else begin
                r_sk_v  <= 1'b1;
            end
        end else if (!i_stall) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sk_v) begin
            if (!i_stall) begin
                r_out <= r_sk;
            end
        end else if (r_v[NS-1]) begin
            if (!r_out_v || !i_stall) begin
                r_out <= n_fmt;
            end else begin
                r_sk  <= n_fmt;
            end
        end
    end

endmodule

### rtl/ncfs_chk.sv
module ncfs_chk (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_valid,
    input logic           o_stall,
    input ncfs_pkg::t_in  i_data,
    input logic           o_valid,
    input logic           i_stall,
    input ncfs_pkg::t_out o_data,
    input logic           i_cfg_we,
    input logic           i_cfg_wdata
);

    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("output or stall active after reset");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(o_valid && i_stall))
        else $error("input stalled without a stalled output beat");

    a_stall_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall && !i_stall |=> !o_stall && o_valid)
        else $error("skid beat not drained");

    a_region_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.region == ncfs_pkg::REG_NONE |->
            o_data.saved_magnitude == '0 && o_data.saved_iteration == '0)
        else $error("saved fields nonzero for region none");

    a_region_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.region == ncfs_pkg::REG_NONE ||
            o_data.region == ncfs_pkg::REG_REAL || o_data.region == ncfs_pkg::REG_IMAG)
        else $error("bad region code");

endmodule

bind newton_cubic_fractal_step_core ncfs_chk u_ncfs_chk (.*);
